/* sv/multichannel_cascaded_highpass_macros.svh */
// Assertion macros shared by the high-pass filter bank RTL.
`ifndef MULTICHANNEL_CASCADED_HIGHPASS_MACROS_SVH
`define MULTICHANNEL_CASCADED_HIGHPASS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCHP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCHP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mchp_pkg.sv */
// Package with widths, constants and shared types of the high-pass filter bank.
package mchp_pkg;

  localparam int unsigned SAMPLE_W      = 32;
  localparam int unsigned CH_W          = 4;
  localparam int unsigned ALPHA_W       = 18;
  localparam int unsigned ORDER_W       = 3;
  localparam int unsigned SUM_W         = SAMPLE_W + 2;
  localparam int unsigned ACC_W         = SUM_W + 2;
  localparam int unsigned STEP_W        = $clog2(ALPHA_W);
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = ALPHA_W;

  localparam int unsigned CHANNELS_DEF  = 16;
  localparam int unsigned MAX_ORDER_DEF = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 18'd131072;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 18'd130907;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;

  localparam logic [SAMPLE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_IDX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_IDX = 1'b1;

  typedef struct packed {
    logic start;
  } stage_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stage_sts_t;

endpackage

/* sv/mchp_if.sv */
// Request and result channel interfaces of the high-pass filter bank.
interface mchp_req_if import mchp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink (input valid, channel, sample, output ready);
endinterface

interface mchp_res_if import mchp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            out_channel;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       was_priming;

  modport source (output valid, out_channel, filtered, was_priming, input ready);
  modport sink (input valid, out_channel, filtered, was_priming, output ready);
endinterface

/* sv/mchp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mchp_ram import mchp_pkg::*; #(
  parameter int unsigned WIDTH = SAMPLE_W,
  parameter int unsigned DEPTH = CHANNELS_DEF * MAX_ORDER_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/mchp_stage.sv */
// Bit-serial first-order high-pass stage: sum, shift-add multiply by alpha, saturate.
module mchp_stage import mchp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stage_ctl_t                 ctl,
  input  logic signed [SAMPLE_W-1:0] prev_out,
  input  logic signed [SAMPLE_W-1:0] value,
  input  logic signed [SAMPLE_W-1:0] prev_in,
  input  logic [ALPHA_W-1:0]         alpha,
  output stage_sts_t                 sts,
  output logic signed [SAMPLE_W-1:0] y
);

  logic                       busy_r;
  logic                       done_r;
  logic [STEP_W-1:0]          cnt_r;
  logic [ALPHA_W-1:0]         alpha_sh_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] y_r;

  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [ACC_W-1:0]    addend;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic [SAMPLE_W-1:0]        y_nxt;
  logic                       last_step;
  logic                       fits;

  assign sum_nxt   = SUM_W'(prev_out) + SUM_W'(value) - SUM_W'(prev_in);
  assign addend    = alpha_sh_r[0] ? ACC_W'(sum_r) : '0;
  assign acc_nxt   = acc_r + addend;
  assign last_step = (cnt_r == STEP_W'(ALPHA_W - 1));

  // The value fits in 32 bits when all bits from the 32-bit sign bit upward agree.
  assign fits  = (&acc_nxt[ACC_W-1:SAMPLE_W-1]) | ~(|acc_nxt[ACC_W-1:SAMPLE_W-1]);
  assign y_nxt = fits ? acc_nxt[SAMPLE_W-1:0] : (acc_nxt[ACC_W-1] ? SAT_NEG : SAT_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step && !ctl.start;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last_step) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Each step adds the sum when the current alpha bit is set, then halves the
  // partial product; the arithmetic shift floors, so the end value is
  // floor(sum * alpha / 2^17). The top alpha bit is added without a shift.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sum_r      <= sum_nxt;
      acc_r      <= '0;
      alpha_sh_r <= alpha;
    end else if (busy_r) begin
      if (last_step) begin
        y_r <= y_nxt;
      end else begin
        acc_r      <= acc_nxt >>> 1;
        alpha_sh_r <= alpha_sh_r >> 1;
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign y        = y_r;

endmodule

/* sv/multichannel_cascaded_highpass.sv */
// Top level of the multichannel cascaded high-pass filter bank.
//
// Requests arrive on in_req (channel, sample); one result per request leaves on
// out_res (out_channel, filtered, was_priming). Both use valid/ready and move
// an item at a clock edge where both are high. cfg_we/cfg_index/cfg_wdata write
// alpha_coeff (index 0) and filter_order (index 1); the user must write them
// only while the bank is idle, as the bank itself does not enforce it. The first
// request on a channel primes it: S_PRIME writes its MAX_ORDER stage history
// entries, and the result is zero with was_priming set. Later requests run the
// active stages one after another through a bit-serial multiplier that takes
// one alpha bit a cycle; each stage passes S_READ (RAM read), S_LOAD (operand
// load) and S_MAC (18 multiply steps, write-back). Priming, the last stage and
// a channel out of range lead to S_DONE, which loads the result register and
// returns to S_IDLE for the next request. One request is in work at a time;
// in_req.ready is high only while the bank waits for a request. The result
// register lets the next request be taken while the previous result waits on
// a stalled receiver; a finished result then holds until the register frees up.
// Synchronous reset clears every channel's primed flag and restores the
// register defaults; the stage history RAMs are not cleared.
`include "multichannel_cascaded_highpass_macros.svh"

module multichannel_cascaded_highpass import mchp_pkg::*; #(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mchp_req_if.sink              in_req,
  mchp_res_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned DEPTH = CHANNELS * MAX_ORDER;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned KW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRIME = 6'b000010,
    S_READ  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_MAC   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ALPHA_W-1:0]         alpha_r;
  logic [ORDER_W-1:0]         order_r;
  logic [CHANNELS-1:0]        primed_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [SAMPLE_W-1:0] value_r;
  logic [KW-1:0]              k_r;
  logic [KW-1:0]              last_k_r;
  logic [ALPHA_W-1:0]         alpha_eff_r;
  logic                       priming_r;
  logic                       out_valid_r;
  logic [CH_W-1:0]            out_ch_r;
  logic signed [SAMPLE_W-1:0] out_filt_r;
  logic                       out_prime_r;

  logic [CW-1:0]              in_idx;
  logic                       in_range;
  logic [KW-1:0]              last_k_nxt;
  logic [AW-1:0]              addr;
  logic                       accept;
  logic                       out_load;
  logic                       ram_we;
  logic [SAMPLE_W-1:0]        prev_in_rd;
  logic [SAMPLE_W-1:0]        prev_out_rd;
  logic [SAMPLE_W-1:0]        prev_out_wr;
  stage_ctl_t                 stg_ctl;
  stage_sts_t                 stg_sts;
  logic signed [SAMPLE_W-1:0] stg_y;

  assign in_idx   = CW'(in_req.channel);
  assign in_range = (32'(in_req.channel) < CHANNELS);
  assign accept   = in_req.valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_res.ready);
  assign addr     = AW'(32'(CW'(ch_r)) * MAX_ORDER + 32'(k_r));

  // An order of zero runs one stage; an order above MAX_ORDER runs them all.
  always_comb begin
    if (order_r == '0) begin
      last_k_nxt = '0;
    end else if (32'(order_r) > MAX_ORDER) begin
      last_k_nxt = KW'(MAX_ORDER - 1);
    end else begin
      last_k_nxt = KW'(order_r - 1'b1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_range) begin
            state_nxt = S_DONE;
          end else if (!primed_r[in_idx]) begin
            state_nxt = S_PRIME;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_PRIME: begin
        if (k_r == KW'(MAX_ORDER - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MAC;
      S_MAC: begin
        if (stg_sts.done) begin
          state_nxt = (k_r == last_k_r) ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_IDX: alpha_r <= cfg_wdata;
        CFG_ORDER_IDX: order_r <= cfg_wdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PRIME && k_r == KW'(MAX_ORDER - 1)) begin
        primed_r[CW'(ch_r)] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload and stage sequencing.
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r        <= in_req.channel;
      value_r     <= in_range ? in_req.sample : '0;
      priming_r   <= in_range && !primed_r[in_idx];
      k_r         <= '0;
      last_k_r    <= last_k_nxt;
      alpha_eff_r <= (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    end else if (state_r == S_PRIME) begin
      k_r <= k_r + 1'b1;
      if (k_r == KW'(MAX_ORDER - 1)) begin
        value_r <= '0;
      end
    end else if (state_r == S_MAC && stg_sts.done) begin
      value_r <= stg_y;
      k_r     <= k_r + 1'b1;
    end
    if (out_load) begin
      out_ch_r    <= ch_r;
      out_filt_r  <= value_r;
      out_prime_r <= priming_r;
    end
  end

  // Priming writes the sample and zero; a finished stage writes its input and output.
  assign ram_we      = (state_r == S_PRIME) || (state_r == S_MAC && stg_sts.done);
  assign prev_out_wr = (state_r == S_PRIME) ? '0 : stg_y;

  mchp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_prev_in_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (value_r),
    .raddr (addr),
    .rdata (prev_in_rd)
  );

  mchp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_prev_out_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (prev_out_wr),
    .raddr (addr),
    .rdata (prev_out_rd)
  );

  assign stg_ctl.start = (state_r == S_LOAD);

  mchp_stage u_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stg_ctl),
    .prev_out (prev_out_rd),
    .value    (value_r),
    .prev_in  (prev_in_rd),
    .alpha    (alpha_eff_r),
    .sts      (stg_sts),
    .y        (stg_y)
  );

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_res.valid       = out_valid_r;
  assign out_res.out_channel = out_ch_r;
  assign out_res.filtered    = out_filt_r;
  assign out_res.was_priming = out_prime_r;

  `MCHP_ASSERT_IMP(a_done_in_mac, clk, rst_n, stg_sts.done, state_r == S_MAC,
                   "stage finished outside MAC state")
  `MCHP_ASSERT_IMP(a_prime_zero, clk, rst_n, out_valid_r && out_prime_r, out_filt_r == '0,
                   "priming result is not zero")
  `MCHP_ASSERT_NXT(a_hold_done, clk, rst_n,
                   (state_r == S_DONE) && out_valid_r && !out_res.ready, state_r == S_DONE,
                   "result left DONE while output was stalled")

endmodule

/* tb/sv/tb_multichannel_cascaded_highpass.sv */
// Self-checking testbench for the multichannel cascaded high-pass filter bank.
`timescale 1ns / 100ps

module tb_multichannel_cascaded_highpass;
  import mchp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_LO = -S32_HI - 1;

  typedef struct {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       was_priming;
  } hp_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mchp_req_if req_if ();
  mchp_res_if res_if ();

  multichannel_cascaded_highpass i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Filter bank state mirrored by the predictor.
  logic [ALPHA_W-1:0]         alpha_reg;
  logic [ORDER_W-1:0]         order_reg;
  logic                       chan_primed [CHANNELS_DEF];
  logic signed [SAMPLE_W-1:0] hist_in [CHANNELS_DEF][MAX_ORDER_DEF];
  logic signed [SAMPLE_W-1:0] hist_out [CHANNELS_DEF][MAX_ORDER_DEF];
  int                         drift_level [CHANNELS_DEF];

  hp_result_t  pending_results [$];
  bit          src_gaps_on;
  bit          sink_stalls_on;
  int          hold_request;
  int unsigned cycle_count;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_cfg_writes;
  int unsigned n_primed;
  int unsigned n_errors;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic hp_result_t highpass_predict(input logic [CH_W-1:0] ch,
                                                  input logic signed [SAMPLE_W-1:0] smp);
    hp_result_t res;
    longint     alpha;
    longint     value;
    longint     acc;
    int         stages;
    res.channel     = ch;
    res.filtered    = '0;
    res.was_priming = 1'b0;
    if (!chan_primed[ch]) begin
      for (int k = 0; k < MAX_ORDER_DEF; k++) begin
        hist_in[ch][k]  = smp;
        hist_out[ch][k] = '0;
      end
      chan_primed[ch] = 1'b1;
      res.was_priming = 1'b1;
      n_primed++;
    end else begin
      alpha  = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);
      stages = int'(order_reg);
      if (stages < 1) stages = 1;
      if (stages > MAX_ORDER_DEF) stages = MAX_ORDER_DEF;
      value = longint'(smp);
      for (int k = 0; k < stages; k++) begin
        acc = longint'(hist_out[ch][k]) + value - longint'(hist_in[ch][k]);
        // The arithmetic shift of the signed product rounds toward minus infinity.
        acc = (acc * alpha) >>> (ALPHA_W - 1);
        if (acc > S32_HI) acc = S32_HI;
        if (acc < S32_LO) acc = S32_LO;
        hist_in[ch][k]  = value[SAMPLE_W-1:0];
        hist_out[ch][k] = acc[SAMPLE_W-1:0];
        value = acc;
      end
      res.filtered = value[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample(input logic [CH_W-1:0] ch);
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6, 7: begin
        // A slowly wandering level per channel, the kind of drift the bank rejects.
        drift_level[ch] = drift_level[ch] + int'($urandom_range(0, 4096)) - 2048;
        v = drift_level[ch];
      end
      8: begin
        case ($urandom_range(0, 3))
          0: v = SAT_POS;
          1: v = SAT_NEG;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = int'($urandom_range(0, 511)) - 256;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ALPHA_ONE;
      2: return CFG_DATA_W'($urandom);
      3: return CFG_DATA_W'($urandom_range(125000, 131072));
      4: return CFG_DATA_W'($urandom_range(131073, 262143));
      default: return ALPHA_RESET;
    endcase
  endfunction

  // Valid is left high after a request is taken so that a following request can go
  // out without a gap; every caller either sends again or calls wait_idle at once.
  task automatic send_sample(input logic [CH_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = src_gaps_on ? idle_length() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.channel <= ch;
    req_if.sample  <= smp;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), highpass_predict(ch, smp));
    n_requests++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ALPHA_IDX) alpha_reg = data[ALPHA_W-1:0];
    else order_reg = data[ORDER_W-1:0];
    n_cfg_writes++;
  endtask

  task automatic test_priming_extremes();
    send_sample(4'd0, SAT_POS);
    send_sample(4'd1, SAT_NEG);
    send_sample(4'd15, '0);
    send_sample(4'd0, SAT_NEG);
    send_sample(4'd1, SAT_POS);
    send_sample(4'd15, '1);
    send_sample(4'd15, 32'sd1);
  endtask

  task automatic test_saturation();
    wait_idle();
    write_reg(CFG_ALPHA_IDX, ALPHA_ONE);
    write_reg(CFG_ORDER_IDX, 18'd4);
    send_sample(4'd2, SAT_NEG);
    send_sample(4'd2, SAT_POS);
    send_sample(4'd2, SAT_POS);
    send_sample(4'd2, SAT_NEG);
    send_sample(4'd3, SAT_POS);
    send_sample(4'd3, SAT_NEG);
    send_sample(4'd3, SAT_NEG);
  endtask

  task automatic test_coefficient_clamp();
    wait_idle();
    write_reg(CFG_ALPHA_IDX, 18'h3FFFF);
    write_reg(CFG_ORDER_IDX, 18'd3);
    send_sample(4'd4, 32'sh0001_0000);
    send_sample(4'd4, -32'sh0002_0000);
    send_sample(4'd4, 32'sh7FFF_0000);
    wait_idle();
    write_reg(CFG_ALPHA_IDX, 18'd131073);
    send_sample(4'd4, 32'sh1234_5678);
  endtask

  task automatic test_order_limits();
    wait_idle();
    write_reg(CFG_ALPHA_IDX, '0);
    write_reg(CFG_ORDER_IDX, 18'd0);
    send_sample(4'd5, 32'sd1000);
    send_sample(4'd5, 32'sd5000);
    wait_idle();
    write_reg(CFG_ALPHA_IDX, 18'd65536);
    write_reg(CFG_ORDER_IDX, 18'd7);
    send_sample(4'd5, -32'sd5000);
    send_sample(4'd5, 32'sd12345);
    wait_idle();
    write_reg(CFG_ORDER_IDX, 18'd5);
    send_sample(4'd5, 32'sd777);
  endtask

  // Stages switched on after priming start from the history that priming left.
  task automatic test_order_change_after_priming();
    wait_idle();
    write_reg(CFG_ALPHA_IDX, 18'd120000);
    write_reg(CFG_ORDER_IDX, 18'd1);
    send_sample(4'd6, 32'sh0001_0000);
    send_sample(4'd6, 32'sh0002_0000);
    wait_idle();
    write_reg(CFG_ORDER_IDX, 18'd4);
    send_sample(4'd6, 32'sh0003_0000);
  endtask

  task automatic test_random_traffic();
    logic [CH_W-1:0]       ch;
    logic [CFG_DATA_W-1:0] order_word;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_reg(CFG_ALPHA_IDX, pick_alpha());
      // Bits above the order field are written with noise; the register keeps the low bits.
      order_word = CFG_DATA_W'($urandom);
      order_word[ORDER_W-1:0] = (ph < 2) ? ORDER_W'(ph * 7) : ORDER_W'($urandom_range(0, 7));
      write_reg(CFG_ORDER_IDX, order_word);
      src_gaps_on    = (ph % 4) != 1;
      sink_stalls_on = (ph % 4) != 2;
      for (int i = 0; i < 190; i++) begin
        if (ph % 2 == 0 && $urandom_range(0, 1) == 0) ch = CH_W'($urandom_range(0, 3));
        else ch = CH_W'($urandom_range(0, 15));
        send_sample(ch, random_sample(ch));
      end
    end
  endtask

  task automatic test_backpressure();
    logic [CH_W-1:0] ch;
    wait_idle();
    write_reg(CFG_ALPHA_IDX, ALPHA_RESET);
    write_reg(CFG_ORDER_IDX, 18'd4);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    // The receiver holds off long enough for the bank to fill and stop taking requests.
    hold_request = 300;
    for (int i = 0; i < 40; i++) begin
      ch = CH_W'($urandom_range(0, 15));
      send_sample(ch, random_sample(ch));
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 10 == 0) wait_idle();
      ch = CH_W'($urandom_range(0, 15));
      send_sample(ch, random_sample(ch));
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        if (sink_stalls_on) stall = idle_length();
      end
    end
  end

  always @(posedge clk) begin : result_check
    hp_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result on channel %0d with no request outstanding", res_if.out_channel);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.out_channel !== want.channel) begin
          $error("out_channel: expected %0d, got %0d", want.channel, res_if.out_channel);
          n_errors++;
        end
        if (res_if.filtered !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered, res_if.filtered);
          n_errors++;
        end
        if (res_if.was_priming !== want.was_priming) begin
          $error("was_priming: expected %0d, got %0d", want.was_priming, res_if.was_priming);
          n_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("multichannel_cascaded_highpass test failed");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.channel <= '0;
    req_if.sample  <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    alpha_reg      = ALPHA_RESET;
    order_reg      = ORDER_RESET;
    for (int c = 0; c < CHANNELS_DEF; c++) chan_primed[c] = 1'b0;
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    hold_request   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_priming_extremes();
    test_saturation();
    test_coefficient_clamp();
    test_order_limits();
    test_order_change_after_priming();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Run covered %0d requests and %0d results on %0d primed channels in %0d cycles,",
             n_requests, n_results, n_primed, cycle_count);
    $display("with %0d register writes across orders 0 to 7 and coefficients 0 to above one.",
             n_cfg_writes);
    if (n_errors == 0) begin
      $display("multichannel_cascaded_highpass test passed");
    end else begin
      $display("multichannel_cascaded_highpass test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/mchp_pkg.sv
sv/mchp_if.sv
sv/mchp_ram.sv
sv/mchp_stage.sv
sv/multichannel_cascaded_highpass.sv
tb/sv/tb_multichannel_cascaded_highpass.sv
